[sv/kce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kce_pkg
// Shared sizes, codes and bundle types of the k-means cluster engine.
// ----------------------------------------------------------------------------
package kce_pkg;

    localparam int MAX_DOCUMENTS = 1024;
    localparam int MAX_CLUSTERS  = 16;
    localparam int MAX_FEATURES  = 16;

    localparam int DOC_W    = $clog2(MAX_DOCUMENTS);
    localparam int CLUS_W   = $clog2(MAX_CLUSTERS);
    localparam int FEAT_W   = $clog2(MAX_FEATURES);
    localparam int CNT_W    = DOC_W + 1;
    localparam int SCORE_W  = 32;
    localparam int SUM_W    = SCORE_W + DOC_W + 1;
    localparam int DIST_W   = 2 * SCORE_W;
    localparam int PASS_W   = 16;
    localparam int ACT_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RUN  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DOCUMENTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEATURES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic [DOC_W-1:0]          doc_index;
        logic [FEAT_W-1:0]         feature_index;
        logic signed [SCORE_W-1:0] score_value;
    } kce_req_t;

    typedef struct packed {
        logic [CLUS_W:0]     k;
        logic [CNT_W-1:0]    n;
        logic [FEAT_W:0]     f;
        logic [PASS_W-1:0]   limit;
    } kce_cfg_t;

    typedef struct packed {
        logic [CLUS_W-1:0] cluster_id;
        logic [PASS_W-1:0] pass_count;
        logic              converged;
    } kce_res_t;

endpackage
`default_nettype wire

[sv/kce_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kce_if
// Request, result and configuration channels of the k-means cluster engine.
// ----------------------------------------------------------------------------
interface kce_in_if;
    logic                                valid;
    logic                                ready;
    logic [kce_pkg::ACT_W-1:0]           action;
    logic [kce_pkg::DOC_W-1:0]           doc_index;
    logic [kce_pkg::FEAT_W-1:0]          feature_index;
    logic signed [kce_pkg::SCORE_W-1:0]  score_value;

    modport source (output valid, action, doc_index, feature_index, score_value,
                    input ready);
    modport sink   (input valid, action, doc_index, feature_index, score_value,
                    output ready);
endinterface

interface kce_out_if;
    logic                         valid;
    logic                         ready;
    logic [kce_pkg::CLUS_W-1:0]   cluster_id;
    logic [kce_pkg::PASS_W-1:0]   pass_count;
    logic                         converged;

    modport source (output valid, cluster_id, pass_count, converged, input ready);
    modport sink   (input valid, cluster_id, pass_count, converged, output ready);
endinterface

interface kce_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [kce_pkg::CFG_IDX_W-1:0]    index;
    logic [kce_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/kce_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kce_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module kce_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [kce_pkg::SUM_W-1:0]    dividend,
    input  wire logic [kce_pkg::CNT_W-1:0]           divisor,
    output logic                                     done,
    output logic signed [kce_pkg::SCORE_W-1:0]       quotient
);

    localparam int MAG_W  = kce_pkg::SUM_W;
    localparam int STEP_W = $clog2(MAG_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [kce_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [MAG_W-1:0]              quo_reg, quo_next;
    logic [kce_pkg::CNT_W-1:0]     den_reg, den_next;
    logic                          neg_reg, neg_next;
    logic [kce_pkg::CNT_W:0]       shifted;
    logic [kce_pkg::CNT_W:0]       trial;
    logic [MAG_W-1:0]              quo_signed;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[MAG_W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            den_next  = divisor;
            neg_next  = dividend[MAG_W-1];
            quo_next  = dividend[MAG_W-1] ? (MAG_W'(0) - MAG_W'(dividend))
                                          : MAG_W'(dividend);
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = trial[kce_pkg::CNT_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[kce_pkg::CNT_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

    assign quo_signed = neg_reg ? (MAG_W'(0) - quo_reg) : quo_reg;
    assign quotient   = quo_signed[kce_pkg::SCORE_W-1:0];
    assign done       = done_reg;

endmodule
`default_nettype wire

[sv/kce_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kce_engine
// Score, sum, mean and assignment memories with the sequencer of Lloyd passes.
// ----------------------------------------------------------------------------
module kce_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire kce_pkg::kce_req_t  req,
    input  wire kce_pkg::kce_cfg_t  cfg,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output kce_pkg::kce_res_t       res
);

    localparam int DOC_W   = kce_pkg::DOC_W;
    localparam int CLUS_W  = kce_pkg::CLUS_W;
    localparam int FEAT_W  = kce_pkg::FEAT_W;
    localparam int CNT_W   = kce_pkg::CNT_W;
    localparam int SCORE_W = kce_pkg::SCORE_W;
    localparam int SUM_W   = kce_pkg::SUM_W;
    localparam int DIST_W  = kce_pkg::DIST_W;
    localparam int PASS_W  = kce_pkg::PASS_W;
    localparam int NCLUS   = kce_pkg::MAX_CLUSTERS;
    localparam int CS_W    = CLUS_W + FEAT_W;
    localparam int DS_W    = DOC_W + FEAT_W;

    typedef enum logic [19:0] {
        ST_CLEAR  = 20'h00001,
        ST_IDLE   = 20'h00002,
        ST_RDWAIT = 20'h00004,
        ST_INIT   = 20'h00008,
        ST_SCLR   = 20'h00010,
        ST_ACC_A  = 20'h00020,
        ST_ACC_R  = 20'h00040,
        ST_ACC_W  = 20'h00080,
        ST_DIV_R  = 20'h00100,
        ST_DIV_S  = 20'h00200,
        ST_DIV_W  = 20'h00400,
        ST_AS_D   = 20'h00800,
        ST_AS_L   = 20'h01000,
        ST_AS_K   = 20'h02000,
        ST_AS_R   = 20'h04000,
        ST_AS_M   = 20'h08000,
        ST_AS_Q   = 20'h10000,
        ST_AS_A   = 20'h20000,
        ST_AS_WB  = 20'h40000,
        ST_PASS   = 20'h80000
    } state_t;

    // Memories.
    logic signed [SCORE_W-1:0] score_mem  [kce_pkg::MAX_DOCUMENTS*kce_pkg::MAX_FEATURES];
    logic signed [SUM_W-1:0]   sum_mem    [NCLUS*kce_pkg::MAX_FEATURES];
    logic signed [SCORE_W-1:0] mean_mem   [NCLUS*kce_pkg::MAX_FEATURES];
    logic [CLUS_W-1:0]         assign_mem [kce_pkg::MAX_DOCUMENTS];

    logic                      score_we;
    logic [DS_W-1:0]           score_waddr, score_raddr;
    logic signed [SCORE_W-1:0] score_q;
    logic                      sum_we;
    logic [CS_W-1:0]           sum_waddr, sum_raddr;
    logic signed [SUM_W-1:0]   sum_wdata, sum_q;
    logic                      mean_we;
    logic [CS_W-1:0]           mean_addr;
    logic signed [SCORE_W-1:0] mean_q;
    logic                      assign_we, assign_re;
    logic [DOC_W-1:0]          assign_raddr;
    logic [CLUS_W-1:0]         assign_wdata, assign_q;

    // Control registers.
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    d_reg, d_next;
    logic [CLUS_W:0]     c_reg, c_next;
    logic [FEAT_W:0]     s_reg, s_next;
    logic [CLUS_W-1:0]   mod_reg, mod_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic                changed_reg, changed_next;
    logic                have_reg, have_next;
    logic [CLUS_W-1:0]   pick_reg, pick_next;
    logic [CLUS_W-1:0]   old_reg, old_next;
    logic [DIST_W-1:0]   best_reg, best_next;
    logic [DIST_W-1:0]   acc_reg, acc_next;
    logic [DIST_W-1:0]   sq_reg, sq_next;
    logic [SCORE_W-1:0]  mag_reg, mag_next;
    logic                valid_reg [NCLUS];
    logic                valid_next [NCLUS];
    logic [CNT_W-1:0]    cnt_reg [NCLUS];
    logic [CNT_W-1:0]    cnt_next [NCLUS];
    logic                res_valid_reg, res_valid_next;
    logic [CLUS_W-1:0]   res_cid_reg, res_cid_next;
    logic [PASS_W-1:0]   last_pass_reg, last_pass_next;
    logic                last_conv_reg, last_conv_next;

    logic                accept;
    logic                res_take;
    logic [CLUS_W-1:0]   cnt_idx;
    logic [CNT_W-1:0]    cnt_sel;
    logic [CLUS_W:0]     c_inc;
    logic [FEAT_W:0]     s_inc;
    logic [CNT_W-1:0]    d_inc;
    logic [CLUS_W:0]     mod_inc;
    logic [PASS_W-1:0]   pass_inc;
    logic [SCORE_W:0]    diff, diff_abs;
    logic [DIST_W:0]     acc_sum;
    logic [DIST_W-1:0]   acc_sat;
    logic                div_start, div_done;
    logic signed [SCORE_W-1:0] div_q;

    kce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_q),
        .divisor  (cnt_sel),
        .done     (div_done),
        .quotient (div_q)
    );

    assign res_take  = res_valid_reg && res_ready;
    assign req_ready = (state_reg == ST_IDLE) && (!res_valid_reg || res_ready);
    assign accept    = req_valid && req_ready;

    assign c_inc    = c_reg + (CLUS_W+1)'(1);
    assign s_inc    = s_reg + (FEAT_W+1)'(1);
    assign d_inc    = d_reg + CNT_W'(1);
    assign mod_inc  = {1'b0, mod_reg} + (CLUS_W+1)'(1);
    assign pass_inc = pass_reg + PASS_W'(1);

    assign cnt_idx = (state_reg == ST_ACC_R) ? assign_q : c_reg[CLUS_W-1:0];
    assign cnt_sel = cnt_reg[cnt_idx];

    assign diff     = {score_q[SCORE_W-1], score_q} - {mean_q[SCORE_W-1], mean_q};
    assign diff_abs = diff[SCORE_W] ? ((SCORE_W+1)'(0) - diff) : diff;
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, sq_reg};
    assign acc_sat  = acc_sum[DIST_W] ? {DIST_W{1'b1}} : acc_sum[DIST_W-1:0];

    // Memory addressing.
    assign score_raddr  = {d_reg[DOC_W-1:0], s_reg[FEAT_W-1:0]};
    assign score_waddr  = {req.doc_index, req.feature_index};
    assign score_we     = accept && (req.action == kce_pkg::ACT_LOAD);
    assign sum_raddr    = {cnt_idx, s_reg[FEAT_W-1:0]};
    assign sum_waddr    = (state_reg == ST_ACC_W) ? {assign_q, s_reg[FEAT_W-1:0]}
                                                  : {c_reg[CLUS_W-1:0], s_reg[FEAT_W-1:0]};
    assign sum_wdata    = (state_reg == ST_ACC_W)
                        ? sum_q + {{(SUM_W-SCORE_W){score_q[SCORE_W-1]}}, score_q}
                        : '0;
    assign sum_we       = (state_reg == ST_SCLR) || (state_reg == ST_ACC_W);
    assign mean_addr    = {c_reg[CLUS_W-1:0], s_reg[FEAT_W-1:0]};
    assign mean_we      = (state_reg == ST_DIV_W) && div_done;
    assign assign_raddr = (state_reg == ST_IDLE) ? req.doc_index : d_reg[DOC_W-1:0];
    assign assign_re    = (accept && (req.action == kce_pkg::ACT_READ))
                       || (state_reg == ST_ACC_A) || (state_reg == ST_AS_D);
    assign assign_we    = (state_reg == ST_CLEAR) || (state_reg == ST_INIT)
                       || ((state_reg == ST_AS_WB) && (pick_reg != old_reg));
    assign assign_wdata = (state_reg == ST_CLEAR) ? '0
                        : (state_reg == ST_INIT)  ? mod_reg : pick_reg;
    assign div_start    = (state_reg == ST_DIV_S) && (cnt_sel != '0);

    always_ff @(posedge clk) begin
        if (score_we) begin
            score_mem[score_waddr] <= req.score_value;
        end
        score_q <= score_mem[score_raddr];
    end

    always_ff @(posedge clk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_q <= sum_mem[sum_raddr];
    end

    always_ff @(posedge clk) begin
        if (mean_we) begin
            mean_mem[mean_addr] <= div_q;
        end
        mean_q <= mean_mem[mean_addr];
    end

    always_ff @(posedge clk) begin
        if (assign_we) begin
            assign_mem[d_reg[DOC_W-1:0]] <= assign_wdata;
        end
        if (assign_re) begin
            assign_q <= assign_mem[assign_raddr];
        end
    end

    always_comb begin
        state_next     = state_reg;
        d_next         = d_reg;
        c_next         = c_reg;
        s_next         = s_reg;
        mod_next       = mod_reg;
        pass_next      = pass_reg;
        changed_next   = changed_reg;
        have_next      = have_reg;
        pick_next      = pick_reg;
        old_next       = old_reg;
        best_next      = best_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        mag_next       = mag_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_take ? 1'b0 : res_valid_reg;
        res_cid_next   = res_cid_reg;
        last_pass_next = last_pass_reg;
        last_conv_next = last_conv_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                d_next = d_inc;
                if (d_reg == CNT_W'(kce_pkg::MAX_DOCUMENTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (req.action == kce_pkg::ACT_RUN) begin
                        d_next     = '0;
                        mod_next   = '0;
                        state_next = ST_INIT;
                    end else if (req.action == kce_pkg::ACT_READ) begin
                        state_next = ST_RDWAIT;
                    end else begin
                        res_valid_next = 1'b1;
                        res_cid_next   = '0;
                    end
                end
            end
            ST_RDWAIT: begin
                res_valid_next = 1'b1;
                res_cid_next   = assign_q;
                state_next     = ST_IDLE;
            end
            ST_INIT: begin
                mod_next = (mod_inc == cfg.k) ? '0 : mod_inc[CLUS_W-1:0];
                d_next   = d_inc;
                if (d_inc == cfg.n) begin
                    c_next       = '0;
                    s_next       = '0;
                    pass_next    = '0;
                    changed_next = 1'b0;
                    state_next   = ST_SCLR;
                end
            end
            ST_SCLR: begin
                for (int i = 0; i < NCLUS; i++) begin
                    cnt_next[i] = '0;
                end
                if (s_inc == cfg.f) begin
                    s_next = '0;
                    c_next = c_inc;
                    if (c_inc == cfg.k) begin
                        d_next     = '0;
                        state_next = ST_ACC_A;
                    end
                end else begin
                    s_next = s_inc;
                end
            end
            ST_ACC_A: begin
                state_next = ST_ACC_R;
            end
            ST_ACC_R: begin
                if (s_reg == '0) begin
                    cnt_next[cnt_idx] = cnt_sel + CNT_W'(1);
                end
                state_next = ST_ACC_W;
            end
            ST_ACC_W: begin
                if (s_inc == cfg.f) begin
                    s_next = '0;
                    d_next = d_inc;
                    if (d_inc == cfg.n) begin
                        c_next     = '0;
                        state_next = ST_DIV_R;
                    end else begin
                        state_next = ST_ACC_A;
                    end
                end else begin
                    s_next     = s_inc;
                    state_next = ST_ACC_R;
                end
            end
            ST_DIV_R: begin
                state_next = ST_DIV_S;
            end
            ST_DIV_S: begin
                if (cnt_sel == '0) begin
                    valid_next[c_reg[CLUS_W-1:0]] = 1'b0;
                    if (s_inc == cfg.f) begin
                        s_next = '0;
                        c_next = c_inc;
                        if (c_inc == cfg.k) begin
                            d_next     = '0;
                            state_next = ST_AS_D;
                        end else begin
                            state_next = ST_DIV_R;
                        end
                    end else begin
                        s_next     = s_inc;
                        state_next = ST_DIV_R;
                    end
                end else begin
                    state_next = ST_DIV_W;
                end
            end
            ST_DIV_W: begin
                if (div_done) begin
                    valid_next[c_reg[CLUS_W-1:0]] = 1'b1;
                    if (s_inc == cfg.f) begin
                        s_next = '0;
                        c_next = c_inc;
                        if (c_inc == cfg.k) begin
                            d_next     = '0;
                            state_next = ST_AS_D;
                        end else begin
                            state_next = ST_DIV_R;
                        end
                    end else begin
                        s_next     = s_inc;
                        state_next = ST_DIV_R;
                    end
                end
            end
            ST_AS_D: begin
                state_next = ST_AS_L;
            end
            ST_AS_L: begin
                old_next   = assign_q;
                pick_next  = assign_q;
                have_next  = 1'b0;
                c_next     = '0;
                state_next = ST_AS_K;
            end
            ST_AS_K: begin
                if (c_reg == cfg.k) begin
                    state_next = ST_AS_WB;
                end else if (!valid_reg[c_reg[CLUS_W-1:0]]) begin
                    c_next = c_inc;
                end else begin
                    acc_next   = '0;
                    s_next     = '0;
                    state_next = ST_AS_R;
                end
            end
            ST_AS_R: begin
                state_next = ST_AS_M;
            end
            ST_AS_M: begin
                mag_next   = diff_abs[SCORE_W-1:0];
                state_next = ST_AS_Q;
            end
            ST_AS_Q: begin
                sq_next    = mag_reg * mag_reg;
                state_next = ST_AS_A;
            end
            ST_AS_A: begin
                acc_next = acc_sat;
                if (s_inc == cfg.f) begin
                    // Strict compare keeps the lowest index on a tie.
                    if (!have_reg || (acc_sat < best_reg)) begin
                        have_next = 1'b1;
                        best_next = acc_sat;
                        pick_next = c_reg[CLUS_W-1:0];
                    end
                    c_next     = c_inc;
                    state_next = ST_AS_K;
                end else begin
                    s_next     = s_inc;
                    state_next = ST_AS_R;
                end
            end
            ST_AS_WB: begin
                if (pick_reg != old_reg) begin
                    changed_next = 1'b1;
                end
                d_next = d_inc;
                state_next = (d_inc == cfg.n) ? ST_PASS : ST_AS_D;
            end
            ST_PASS: begin
                pass_next = pass_inc;
                if (changed_reg && (pass_inc < cfg.limit)) begin
                    c_next       = '0;
                    s_next       = '0;
                    changed_next = 1'b0;
                    state_next   = ST_SCLR;
                end else begin
                    last_pass_next = pass_inc;
                    last_conv_next = !changed_reg;
                    res_valid_next = 1'b1;
                    res_cid_next   = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            d_reg         <= '0;
            res_valid_reg <= 1'b0;
            last_pass_reg <= '0;
            last_conv_reg <= 1'b0;
            for (int i = 0; i < NCLUS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg     <= state_next;
            d_reg         <= d_next;
            res_valid_reg <= res_valid_next;
            last_pass_reg <= last_pass_next;
            last_conv_reg <= last_conv_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        c_reg       <= c_next;
        s_reg       <= s_next;
        mod_reg     <= mod_next;
        pass_reg    <= pass_next;
        changed_reg <= changed_next;
        have_reg    <= have_next;
        pick_reg    <= pick_next;
        old_reg     <= old_next;
        best_reg    <= best_next;
        acc_reg     <= acc_next;
        sq_reg      <= sq_next;
        mag_reg     <= mag_next;
        cnt_reg     <= cnt_next;
        res_cid_reg <= res_cid_next;
    end

    assign res_valid      = res_valid_reg;
    assign res.cluster_id = res_cid_reg;
    assign res.pass_count = last_pass_reg;
    assign res.converged  = last_conv_reg;

endmodule
`default_nettype wire

[sv/kmeans_cluster_engine_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmeans_cluster_engine_core
// Lloyd k-means clustering of documents held in on-chip score memory.
// ----------------------------------------------------------------------------
// The block has three channels. The cfg channel writes num_clusters,
// num_documents, num_features and max_iterations by index and is always ready.
// Each request on the item channel gives exactly one result on the result
// channel. A load request writes one score and leaves the engine idle, so
// loads stream at one per cycle while the result path does not stall; its
// result passes through the engine's result register and then the output
// register. A read request passes through a memory-read wait state before
// the engine returns to idle, and its result then takes the same path.
// A run request assigns the documents round robin and then runs passes until
// no document moves or the pass limit is hit. Each pass forms the means with
// the bit-serial divider; the score and mean memories, one read port each,
// set the per-feature cost of the distance loop.
// After reset the assignment memory is swept to zero, one entry per cycle
// over all 1024 entries, and item ready stays low until the sweep is done.
// Scores and means are not cleared. A finished result sits in an output
// register; while the receiver stalls, one more request is accepted and its
// result is held inside the engine until the output register frees up.
// ----------------------------------------------------------------------------
module kmeans_cluster_engine_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kce_in_if.sink     item,
    kce_out_if.source  result,
    kce_cfg_if.sink    cfg
);

    logic [kce_pkg::CLUS_W:0]     num_clusters_reg;
    logic [kce_pkg::CNT_W-1:0]    num_documents_reg;
    logic [kce_pkg::FEAT_W:0]     num_features_reg;
    logic [kce_pkg::PASS_W-1:0]   max_iterations_reg;

    kce_pkg::kce_cfg_t  eng_cfg;
    kce_pkg::kce_req_t  eng_req;
    kce_pkg::kce_res_t  eng_res;
    logic               eng_ready;
    logic               eng_res_valid;
    logic               eng_res_ready;

    logic               out_valid_reg;
    kce_pkg::kce_res_t  out_reg;

    // Configuration writes land directly; the registers keep the raw low bits of the data.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            num_clusters_reg   <= (kce_pkg::CLUS_W+1)'(1);
            num_documents_reg  <= kce_pkg::CNT_W'(1);
            num_features_reg   <= (kce_pkg::FEAT_W+1)'(1);
            max_iterations_reg <= kce_pkg::PASS_W'(1000);
        end else if (cfg.valid) begin
            unique case (cfg.index)
                kce_pkg::CFG_NUM_CLUSTERS:
                    num_clusters_reg <= cfg.data[kce_pkg::CLUS_W:0];
                kce_pkg::CFG_NUM_DOCUMENTS:
                    num_documents_reg <= cfg.data[kce_pkg::CNT_W-1:0];
                kce_pkg::CFG_NUM_FEATURES:
                    num_features_reg <= cfg.data[kce_pkg::FEAT_W:0];
                kce_pkg::CFG_MAX_ITERATIONS:
                    max_iterations_reg <= cfg.data[kce_pkg::PASS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Registers are saturated into their legal ranges where they are used.
    always_comb begin
        if (num_clusters_reg == '0) begin
            eng_cfg.k = (kce_pkg::CLUS_W+1)'(1);
        end else if (num_clusters_reg > (kce_pkg::CLUS_W+1)'(kce_pkg::MAX_CLUSTERS)) begin
            eng_cfg.k = (kce_pkg::CLUS_W+1)'(kce_pkg::MAX_CLUSTERS);
        end else begin
            eng_cfg.k = num_clusters_reg;
        end
        if (num_documents_reg == '0) begin
            eng_cfg.n = kce_pkg::CNT_W'(1);
        end else if (num_documents_reg > kce_pkg::CNT_W'(kce_pkg::MAX_DOCUMENTS)) begin
            eng_cfg.n = kce_pkg::CNT_W'(kce_pkg::MAX_DOCUMENTS);
        end else begin
            eng_cfg.n = num_documents_reg;
        end
        if (num_features_reg == '0) begin
            eng_cfg.f = (kce_pkg::FEAT_W+1)'(1);
        end else if (num_features_reg > (kce_pkg::FEAT_W+1)'(kce_pkg::MAX_FEATURES)) begin
            eng_cfg.f = (kce_pkg::FEAT_W+1)'(kce_pkg::MAX_FEATURES);
        end else begin
            eng_cfg.f = num_features_reg;
        end
        eng_cfg.limit = (max_iterations_reg == '0) ? kce_pkg::PASS_W'(1)
                                                   : max_iterations_reg;
    end

    assign eng_req.action        = item.action;
    assign eng_req.doc_index     = item.doc_index;
    assign eng_req.feature_index = item.feature_index;
    assign eng_req.score_value   = item.score_value;
    assign item.ready            = eng_ready;

    kce_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (item.valid),
        .req_ready (eng_ready),
        .req       (eng_req),
        .cfg       (eng_cfg),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res)
    );

    // Output register: takes the engine's result whenever it is empty or
    // being drained in the same cycle.
    assign eng_res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (eng_res_ready) begin
            out_valid_reg <= eng_res_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (eng_res_ready && eng_res_valid) begin
            out_reg <= eng_res;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.cluster_id = out_reg.cluster_id;
    assign result.pass_count = out_reg.pass_count;
    assign result.converged  = out_reg.converged;

endmodule
`default_nettype wire

[sv/kce_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kce_checker
// Port-level checks of the k-means cluster engine, bound to the top level.
// ----------------------------------------------------------------------------
module kce_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         item_valid,
    input wire logic                         item_ready,
    input wire logic [kce_pkg::ACT_W-1:0]    item_action,
    input wire logic                         result_valid,
    input wire logic                         result_ready,
    input wire logic [kce_pkg::CLUS_W-1:0]   result_cluster_id,
    input wire logic [kce_pkg::PASS_W-1:0]   result_pass_count,
    input wire logic                         result_converged
);

    // A stalled result stays offered with the same payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
            && $stable(result_cluster_id) && $stable(result_pass_count)
            && $stable(result_converged))
        else $error("stalled result changed");

    // A converged run always performed at least one pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_converged |-> result_pass_count != '0)
        else $error("converged with zero passes");

    // Run and read requests take the engine out of idle, so item ready drops after they are accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready
            && (item_action == kce_pkg::ACT_RUN || item_action == kce_pkg::ACT_READ)
        |=> !item_ready)
        else $error("request accepted while engine busy");

endmodule

bind kmeans_cluster_engine_core kce_checker u_kce_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .item_action       (item.action),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_cluster_id (result.cluster_id),
    .result_pass_count (result.pass_count),
    .result_converged  (result.converged)
);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-means cluster engine. Score loads, clustering
// runs and assignment reads are sent over the item channel while a bit-exact
// clustering predictor forecasts each result, which is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    import kce_pkg::*;

    localparam int LIMIT_CYCLES = 40_000_000;

    // Action code that the engine leaves unused.
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    logic clk;
    logic rst_n;

    kce_in_if  item_ch ();
    kce_out_if res_ch ();
    kce_cfg_if cfg_ch ();

    kmeans_cluster_engine_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Shadow copy of the engine's registers and memories.
    logic [4:0]  reg_clusters;
    logic [10:0] reg_documents;
    logic [4:0]  reg_features;
    logic [15:0] reg_iterations;

    int          score_mem [MAX_DOCUMENTS*MAX_FEATURES];
    bit          score_known [MAX_DOCUMENTS*MAX_FEATURES];
    int          mean_mem [MAX_CLUSTERS*MAX_FEATURES];
    bit          mean_ok [MAX_CLUSTERS];
    logic [3:0]  cluster_of [MAX_DOCUMENTS];
    logic [15:0] last_passes;
    logic        last_settled;

    kce_res_t    pending_results [$];
    int          mismatches;
    longint      cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    // The clock runs at 12 ns.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // A cycle counter guards against a hung engine.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic int clamp_to(int v, int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Distance of one document to one mean: exact squares, saturating sum.
    function automatic longint unsigned doc_distance(int d, int c, int f);
        longint unsigned acc;
        longint unsigned mag;
        longint unsigned sq;
        longint          diff;
        acc = 0;
        for (int s = 0; s < f; s++)
        begin
            diff = longint'(score_mem[d*MAX_FEATURES+s]) - longint'(mean_mem[c*MAX_FEATURES+s]);
            mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
            sq   = mag * mag;
            if (acc > (64'hFFFF_FFFF_FFFF_FFFF - sq))
                acc = 64'hFFFF_FFFF_FFFF_FFFF;
            else
                acc = acc + sq;
        end
        return acc;
    endfunction

    // Mean of each cluster, truncating toward zero; empty clusters drop out.
    function automatic void update_means(int k, int n, int f);
        longint sums [MAX_FEATURES];
        int      members;
        for (int c = 0; c < k; c++)
        begin
            members = 0;
            for (int s = 0; s < MAX_FEATURES; s++)
                sums[s] = 0;
            for (int d = 0; d < n; d++)
            begin
                if (cluster_of[d] == c)
                begin
                    for (int s = 0; s < f; s++)
                        sums[s] += longint'(score_mem[d*MAX_FEATURES+s]);
                    members++;
                end
            end
            mean_ok[c] = (members != 0);
            for (int s = 0; s < f; s++)
                mean_mem[c*MAX_FEATURES+s] = (members != 0) ? int'(sums[s] / members) : 0;
        end
    endfunction

    // Moves every document to its nearest valid mean, lowest index on ties.
    function automatic bit move_documents(int k, int n, int f);
        bit              moved;
        bit              found;
        longint unsigned best;
        longint unsigned span;
        logic [3:0]      pick;
        moved = 1'b0;
        for (int d = 0; d < n; d++)
        begin
            found = 1'b0;
            best  = 0;
            pick  = cluster_of[d];
            for (int c = 0; c < k; c++)
            begin
                if (mean_ok[c])
                begin
                    span = doc_distance(d, c, f);
                    if (!found || span < best)
                    begin
                        found = 1'b1;
                        best  = span;
                        pick  = c[3:0];
                    end
                end
            end
            if (pick != cluster_of[d])
            begin
                cluster_of[d] = pick;
                moved = 1'b1;
            end
        end
        return moved;
    endfunction

    function automatic void cluster_documents();
        int k;
        int n;
        int f;
        int lim;
        int passes;
        bit moved;
        k   = clamp_to(reg_clusters, MAX_CLUSTERS);
        n   = clamp_to(reg_documents, MAX_DOCUMENTS);
        f   = clamp_to(reg_features, MAX_FEATURES);
        lim = clamp_to(reg_iterations, 65535);
        for (int d = 0; d < n; d++)
            cluster_of[d] = 4'(d % k);
        moved  = 1'b1;
        passes = 0;
        while (moved && passes < lim)
        begin
            update_means(k, n, f);
            moved = move_documents(k, n, f);
            passes++;
        end
        last_passes  = passes[15:0];
        last_settled = !moved;
    endfunction

    // Applies one accepted request to the shadow state and forms its result.
    function automatic kce_res_t engine_response(kce_req_t req);
        kce_res_t r;
        r.cluster_id = '0;
        if (req.action == ACT_LOAD)
        begin
            score_mem[req.doc_index*MAX_FEATURES+req.feature_index]   = req.score_value;
            score_known[req.doc_index*MAX_FEATURES+req.feature_index] = 1'b1;
        end
        else if (req.action == ACT_RUN)
            cluster_documents();
        else if (req.action == ACT_READ)
            r.cluster_id = cluster_of[req.doc_index];
        r.pass_count = last_passes;
        r.converged  = last_settled;
        return r;
    endfunction

    // Sends one request; valid stays up after acceptance unless a gap follows.
    task automatic send_request(logic [ACT_W-1:0] act, int doc, int feat, int score);
        kce_req_t req;
        req.action        = act;
        req.doc_index     = doc[DOC_W-1:0];
        req.feature_index = feat[FEAT_W-1:0];
        req.score_value   = score;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.action        <= req.action;
        item_ch.doc_index     <= req.doc_index;
        item_ch.feature_index <= req.feature_index;
        item_ch.score_value   <= req.score_value;
        do
            @(posedge clk);
        while (!item_ch.ready);
        pending_results.push_back(engine_response(req));
    endtask

    // Every request returns a result, so an empty queue means the engine is idle.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_NUM_CLUSTERS:   reg_clusters   = value[4:0];
            CFG_NUM_DOCUMENTS:  reg_documents  = value[10:0];
            CFG_NUM_FEATURES:   reg_features   = value[4:0];
            CFG_MAX_ITERATIONS: reg_iterations = value[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(int k, int n, int f, int iters);
        write_register(CFG_NUM_CLUSTERS, k);
        write_register(CFG_NUM_DOCUMENTS, n);
        write_register(CFG_NUM_FEATURES, f);
        write_register(CFG_MAX_ITERATIONS, iters);
    endtask

    // Mostly scores near a few centers, so runs settle into real clusters;
    // now and then a value from the whole 32-bit range.
    function automatic int random_score(int doc);
        if ($urandom_range(5) == 0)
            return int'($urandom);
        return ((doc % 3) - 1) * 32'h0040_0000 + int'($urandom_range(32'h0002_0000)) - 32'h0001_0000;
    endfunction

    // Loads every score a run with the current settings will touch.
    task automatic load_dataset();
        int n;
        int f;
        n = clamp_to(reg_documents, MAX_DOCUMENTS);
        f = clamp_to(reg_features, MAX_FEATURES);
        for (int d = 0; d < n; d++)
            for (int s = 0; s < f; s++)
                send_request(ACT_LOAD, d, s, random_score(d));
    endtask

    function automatic bit dataset_complete();
        int n;
        int f;
        n = clamp_to(reg_documents, MAX_DOCUMENTS);
        f = clamp_to(reg_features, MAX_FEATURES);
        for (int d = 0; d < n; d++)
            for (int s = 0; s < f; s++)
                if (!score_known[d*MAX_FEATURES+s])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Result checker; the receiver stalls at random while it runs.
    always @(posedge clk)
    begin
        kce_res_t want;
        if (rst_n)
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb_top: unexpected result cluster=%0d passes=%0d settled=%0b",
                             res_ch.cluster_id, res_ch.pass_count, res_ch.converged);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.cluster_id !== want.cluster_id
                    || res_ch.pass_count !== want.pass_count
                    || res_ch.converged !== want.converged)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb_top: mismatch exp cluster=%0d passes=%0d settled=%0b got cluster=%0d passes=%0d settled=%0b",
                                 want.cluster_id, want.pass_count, want.converged,
                                 res_ch.cluster_id, res_ch.pass_count, res_ch.converged);
                end
            end
        end
    end

    function automatic void set_idling(int mode);
        send_idle_pct  = (mode == 0) ? 10 : (mode == 1) ? 67 : 0;
        recv_stall_pct = (mode == 0) ? 67 : (mode == 1) ? 10 : 0;
    endfunction

    // Extreme scores, reads before any run, empty clusters, ties, a capped
    // run, saturated distances and the unused action.
    task automatic test_directed();
        set_idling(0);
        send_request(ACT_READ, 0, 0, 0);
        configure(4, 2, 2, 1000);
        send_request(ACT_LOAD, 0, 0, 32'h7FFF_FFFF);
        send_request(ACT_LOAD, 0, 1, 32'h7FFF_FFFF);
        send_request(ACT_LOAD, 1, 0, 32'h8000_0000);
        send_request(ACT_LOAD, 1, 1, 32'h8000_0000);
        // Two clusters stay empty and the far distances saturate.
        send_request(ACT_RUN, 0, 0, 0);
        send_request(ACT_READ, 0, 0, 0);
        send_request(ACT_READ, 1, 15, 0);
        send_request(ACT_READ, 1023, 0, 0);
        send_request(ACT_SPARE, 1023, 15, -1);
        // Equal documents give tied distances.
        configure(2, 4, 1, 1);
        send_request(ACT_LOAD, 2, 0, 0);
        send_request(ACT_LOAD, 3, 0, 0);
        send_request(ACT_LOAD, 1, 0, 0);
        send_request(ACT_LOAD, 0, 0, -1);
        send_request(ACT_RUN, 0, 0, 0);
        send_request(ACT_READ, 3, 0, 0);
        // A limit of one pass where documents still move.
        send_request(ACT_LOAD, 0, 0, 32'h0100_0000);
        send_request(ACT_LOAD, 1, 0, 32'h0100_0000);
        send_request(ACT_RUN, 0, 0, 0);
        // Zero and oversized registers clamp.
        configure(0, 0, 31, 0);
        for (int s = 0; s < MAX_FEATURES; s++)
            send_request(ACT_LOAD, 0, s, random_score(s));
        send_request(ACT_RUN, 0, 0, 0);
        send_request(ACT_READ, 0, 0, 0);
    endtask

    // Register extremes: all clusters and features, then the largest pass
    // limit over the scores already loaded.
    task automatic test_register_extremes();
        set_idling(2);
        configure(16, 16, 16, 2);
        load_dataset();
        send_request(ACT_RUN, 0, 0, 0);
        for (int d = 0; d < 16; d++)
            send_request(ACT_READ, d, 0, 0);
        configure(1, 16, 1, 65535);
        send_request(ACT_RUN, 0, 0, 0);
        send_request(ACT_READ, 15, 0, 0);
    endtask

    // Random phases: a fresh data set, then a mix of loads, reads, runs and unused actions.
    task automatic test_random_traffic(int mode);
        int k;
        int n;
        int f;
        int iters;
        int pick;
        set_idling(mode);
        for (int phase = 0; phase < 4; phase++)
        begin
            k = $urandom_range(5, 1);
            n = $urandom_range(12, 1);
            f = $urandom_range(4, 1);
            case ($urandom_range(3))
                0: iters = 1;
                1: iters = $urandom_range(3, 2);
                2: iters = 65535;
                default: iters = $urandom_range(65535, 1);
            endcase
            configure(k, n, f, iters);
            load_dataset();
            for (int i = 0; i < 22; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    send_request(ACT_READ, $urandom_range(1023), $urandom_range(15), int'($urandom));
                else if (pick < 48 && dataset_complete())
                    send_request(ACT_RUN, $urandom_range(1023), $urandom_range(15), int'($urandom));
                else if (pick < 53)
                    send_request(ACT_SPARE, $urandom_range(1023), $urandom_range(15), int'($urandom));
                else if (pick < 85)
                    send_request(ACT_LOAD, $urandom_range(n-1), $urandom_range(f-1),
                                 random_score($urandom_range(2)));
                else
                    send_request(ACT_LOAD, $urandom_range(1023), $urandom_range(15), int'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cycle_count    = 0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        reg_clusters   = 5'd1;
        reg_documents  = 11'd1;
        reg_features   = 5'd1;
        reg_iterations = 16'd1000;
        last_passes    = '0;
        last_settled   = 1'b0;
        for (int i = 0; i < MAX_DOCUMENTS*MAX_FEATURES; i++)
        begin
            score_mem[i]   = 0;
            score_known[i] = 1'b0;
        end
        for (int i = 0; i < MAX_DOCUMENTS; i++)
            cluster_of[i] = '0;
        for (int i = 0; i < MAX_CLUSTERS; i++)
            mean_ok[i] = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.action        = ACT_LOAD;
        item_ch.doc_index     = '0;
        item_ch.feature_index = '0;
        item_ch.score_value   = '0;
        res_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_NUM_CLUSTERS;
        cfg_ch.data           = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_random_traffic(0);
        test_random_traffic(1);
        test_random_traffic(2);

        drain_results();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

[kmeans_cluster_engine_core.f]
sv/kce_pkg.sv
sv/kce_if.sv
sv/kce_div.sv
sv/kce_engine.sv
sv/kmeans_cluster_engine_core.sv
sv/kce_checker.sv
tb/tb_top.sv
